/* hdl/double_ended_queue_top_assert.svh */
// Assertion macros for the deque block.
// All checks are sampled at i_clk and disabled while i_rst_n is low.
`ifndef DOUBLE_ENDED_QUEUE_TOP_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_TOP_ASSERT_SVH

// Same-cycle implication.
`define DQ_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define DQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/dq_pkg.sv */
// ----------------------------------------------------------------------------
// dq_pkg
// Shared types and constants of the double-ended queue.
// ----------------------------------------------------------------------------
`default_nettype none

package dq_pkg;

    localparam int CAPACITY_DEF     = 16;
    localparam int ELEMENT_BITS_DEF = 8;
    localparam int OPCODE_W         = 3;
    localparam int VALUE_W          = 8;
    localparam int STATUS_W         = 2;
    localparam int COUNT_OUT_W      = 5;

    typedef enum logic [OPCODE_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_REAR  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_REAR   = 3'd3,
        OP_PEEK_FRONT = 3'd4,
        OP_PEEK_REAR  = 3'd5
    } t_opcode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // Per-cell move control.
    typedef struct packed {
        logic shift_rear;   // take neighbor toward front (push front)
        logic shift_front;  // take neighbor toward rear (pop front)
        logic load;         // take the pushed value (push rear)
    } t_cell_ctl;

endpackage

`default_nettype wire

/* hdl/dq_in_if.sv */
// ----------------------------------------------------------------------------
// dq_in_if
// Operation channel: opcode and element value.
// ----------------------------------------------------------------------------
`default_nettype none

interface dq_in_if import dq_pkg::*;;
    logic                valid;
    logic                ready;
    logic [OPCODE_W-1:0] opcode;
    logic [VALUE_W-1:0]  push_value;

    modport source (output valid, output opcode, output push_value, input ready);
    modport sink   (input valid, input opcode, input push_value, output ready);
endinterface

`default_nettype wire

/* hdl/dq_out_if.sv */
// ----------------------------------------------------------------------------
// dq_out_if
// Result channel: read value, status, empty flag and fill count.
// ----------------------------------------------------------------------------
`default_nettype none

interface dq_out_if import dq_pkg::*;;
    logic                   valid;
    logic                   ready;
    logic [VALUE_W-1:0]     read_value;
    logic [STATUS_W-1:0]    status;
    logic                   is_empty;
    logic [COUNT_OUT_W-1:0] fill_count;

    modport source (output valid, output read_value, output status, output is_empty,
                    output fill_count, input ready);
    modport sink   (input valid, input read_value, input status, input is_empty,
                    input fill_count, output ready);
endinterface

`default_nettype wire

/* hdl/dq_cell.sv */
// ----------------------------------------------------------------------------
// dq_cell
// One element slot of the shifting deque row.
// ----------------------------------------------------------------------------
`default_nettype none

module dq_cell import dq_pkg::*; #(
    parameter int ELEMENT_BITS = ELEMENT_BITS_DEF
) (
    input  wire                     i_clk,
    input  t_cell_ctl               i_ctl,
    input  wire  [ELEMENT_BITS-1:0] i_from_front,
    input  wire  [ELEMENT_BITS-1:0] i_from_rear,
    input  wire  [ELEMENT_BITS-1:0] i_push,
    output logic [ELEMENT_BITS-1:0] o_data
);

    logic [ELEMENT_BITS-1:0] r_data;
    logic [ELEMENT_BITS-1:0] n_data;

    always_comb begin
        priority if (i_ctl.shift_rear) begin
            n_data = i_from_front;
        end else if (i_ctl.shift_front) begin
            n_data = i_from_rear;
        end else if (i_ctl.load) begin
            n_data = i_push;
        end else begin
            n_data = r_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

`default_nettype wire

/* hdl/double_ended_queue_top.sv */
// ----------------------------------------------------------------------------
// double_ended_queue_top
// Bounded deque kept as a row of shifting cells, front element in cell 0.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries one transaction per operation (opcode, push_value); o_out
//   returns exactly one transaction per operation (read_value, status,
//   is_empty, fill_count), in order.
//   A result is registered and valid on o_out in the cycle after its
//   operation is accepted. Throughput: one operation per cycle while o_out
//   is not stalled; the count register and the cell row are updated in the
//   same cycle, so the next operation sees the new contents at once.
//   Push front shifts the whole row toward the rear, pop front shifts it
//   toward the front; push rear writes the cell at the count; the rear
//   element is picked out of the row by an AND-OR select on count - 1.
//   Reset empties the queue (count cleared); cell contents are not cleared.
//   When the receiver stalls, the result register holds and i_in.ready
//   drops until the result is taken; with o_out.ready high, operations
//   stream without bubbles.
// ----------------------------------------------------------------------------
`default_nettype none

module double_ended_queue_top import dq_pkg::*; #(
    parameter int CAPACITY     = CAPACITY_DEF,
    parameter int ELEMENT_BITS = ELEMENT_BITS_DEF
) (
    input  wire      i_clk,
    input  wire      i_rst_n,
    dq_in_if.sink    i_in,
    dq_out_if.source o_out
);

`include "double_ended_queue_top_assert.svh"

    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    logic [CW-1:0]          r_count;
    logic [CW-1:0]          n_count;
    logic                   r_out_valid;
    logic [VALUE_W-1:0]     r_read_value;
    logic [VALUE_W-1:0]     n_read_value;
    t_status                r_status;
    t_status                n_status;
    logic                   r_is_empty;
    logic [COUNT_OUT_W-1:0] r_fill_count;

    logic                    w_accept;
    logic                    w_full;
    logic                    w_empty;
    logic                    w_push_front;
    logic                    w_push_rear;
    logic                    w_pop_front;
    logic [CW-1:0]           w_last;
    logic [ELEMENT_BITS-1:0] w_push;
    logic [ELEMENT_BITS-1:0] w_rear;
    logic [ELEMENT_BITS-1:0] w_data [CAPACITY];
    logic [ELEMENT_BITS-1:0] w_tap  [CAPACITY];
    logic [ELEMENT_BITS+VALUE_W-1:0] w_push_ext;
    logic [ELEMENT_BITS+VALUE_W-1:0] w_read_ext;
    logic [CW+COUNT_OUT_W-1:0]       w_count_ext;

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_full     = (r_count == CAP_C);
    assign w_empty    = (r_count == '0);
    assign w_last     = r_count - 1'b1;

    assign w_push_ext = {{ELEMENT_BITS{1'b0}}, i_in.push_value};
    assign w_push     = w_push_ext[ELEMENT_BITS-1:0];

    // Decode
    always_comb begin
        w_push_front = 1'b0;
        w_push_rear  = 1'b0;
        w_pop_front  = 1'b0;
        n_count      = r_count;
        n_status     = ST_OK;
        w_read_ext   = '0;
        unique case (i_in.opcode)
            OP_PUSH_FRONT, OP_PUSH_REAR: begin
                if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    w_push_front = (i_in.opcode == OP_PUSH_FRONT);
                    w_push_rear  = (i_in.opcode == OP_PUSH_REAR);
                    n_count      = r_count + 1'b1;
                end
            end
            OP_POP_FRONT, OP_PEEK_FRONT: begin
                if (w_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    w_read_ext  = {{VALUE_W{1'b0}}, w_data[0]};
                    w_pop_front = (i_in.opcode == OP_POP_FRONT);
                    if (i_in.opcode == OP_POP_FRONT) begin
                        n_count = r_count - 1'b1;
                    end
                end
            end
            OP_POP_REAR, OP_PEEK_REAR: begin
                if (w_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    w_read_ext = {{VALUE_W{1'b0}}, w_rear};
                    if (i_in.opcode == OP_POP_REAR) begin
                        n_count = r_count - 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
        n_read_value = w_read_ext[VALUE_W-1:0];
    end

    // Cell row
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        localparam logic [CW-1:0] IDX = CW'(i);
        t_cell_ctl               w_ctl;
        logic [ELEMENT_BITS-1:0] w_front_in;
        logic [ELEMENT_BITS-1:0] w_rear_in;

        assign w_ctl.shift_rear  = w_accept && w_push_front;
        assign w_ctl.shift_front = w_accept && w_pop_front;
        assign w_ctl.load        = w_accept && w_push_rear && (r_count == IDX);

        if (i == 0) begin : g_first
            assign w_front_in = w_push;
        end else begin : g_mid_f
            assign w_front_in = w_data[i-1];
        end
        if (i == CAPACITY - 1) begin : g_last
            assign w_rear_in = w_data[i];
        end else begin : g_mid_r
            assign w_rear_in = w_data[i+1];
        end

        dq_cell #(
            .ELEMENT_BITS(ELEMENT_BITS)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctl       (w_ctl),
            .i_from_front(w_front_in),
            .i_from_rear (w_rear_in),
            .i_push      (w_push),
            .o_data      (w_data[i])
        );

        assign w_tap[i] = (w_last == IDX) ? w_data[i] : '0;
    end

    always_comb begin
        w_rear = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            w_rear = w_rear | w_tap[k];
        end
    end

    assign w_count_ext = {{COUNT_OUT_W{1'b0}}, n_count};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_read_value <= n_read_value;
            r_status     <= n_status;
            r_is_empty   <= (n_count == '0);
            r_fill_count <= w_count_ext[COUNT_OUT_W-1:0];
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.read_value = r_read_value;
    assign o_out.status     = r_status;
    assign o_out.is_empty   = r_is_empty;
    assign o_out.fill_count = r_fill_count;

    `DQ_ASSERT_NOW(a_count_bound, 1'b1, r_count <= CAP_C, "count above capacity")
    `DQ_ASSERT_NEXT(a_push_grows, w_accept && (w_push_front || w_push_rear),
        r_count == CW'($past(r_count) + 1'b1), "push did not grow count")
    `DQ_ASSERT_NEXT(a_result_follows, w_accept, r_out_valid, "missing result")
    `DQ_ASSERT_NOW(a_empty_zero, r_out_valid && (r_status == ST_EMPTY),
        r_read_value == '0, "nonzero value on empty status")

endmodule

`default_nettype wire
